FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

  // result queue depth: two results per byte plus one waiting at the output
  localparam int QDEPTH = 3;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CP_W   = 21;
  localparam int UNIT_W = 16;

  // surrogate ranges and the supplementary plane base
  localparam logic [UNIT_W-1:0] SURR_HI_MIN = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [UNIT_W-1:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [UNIT_W-1:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h10000;

  // ascii characters that matter to the parser
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS_CTL = 8'h08;
  localparam logic [7:0] CH_FF_CTL = 8'h0C;
  localparam logic [7:0] CH_LF_CTL = 8'h0A;
  localparam logic [7:0] CH_CR_CTL = 8'h0D;
  localparam logic [7:0] CH_HT_CTL = 8'h09;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESC    = 3'd1,
    M_HEX1   = 3'd2,
    M_BS2    = 3'd3,
    M_U2     = 3'd4,
    M_HEX2   = 3'd5,
    M_DROP   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_CODE   = 2'd0,
    ST_END    = 2'd1,
    ST_BADESC = 2'd2,
    ST_BADUNI = 2'd3
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    status_t         st;
    logic            fin;
  } result_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // simple escapes: {known, character}
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_B:      r = {1'b1, CH_BS_CTL};
      CH_F:      r = {1'b1, CH_FF_CTL};
      CH_N:      r = {1'b1, CH_LF_CTL};
      CH_R:      r = {1'b1, CH_CR_CTL};
      CH_T:      r = {1'b1, CH_HT_CTL};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/jsu_if.sv
interface jsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface jsu_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic        run_end;

  modport source (output valid, output code_point, output status, output run_end,
                  input ready);
  modport sink (input valid, input code_point, input status, input run_end,
                output ready);
endinterface

FILE: hw/rtl/json_string_unescape.sv
// json string body unescaper
//
// bytes: one raw byte of an escaped string body per request, last_byte set on
//   the final byte of each string
// results: one decoded code point per request (status 0), and after the final
//   byte one closing request with run_end set: end success, invalid escape or
//   invalid unicode; after an error the rest of that string gives nothing
//
// a byte's results are registered in the result queue and show on results once
//   those ahead are taken; throughput: one byte per cycle while bytes.ready is
//   high; a byte that closes a string with a code point gives two results
// the figure is set by the three-entry result queue: bytes are taken while at
//   most one result waits in it, so the two results of one byte always fit
//
// reset: parser back in normal text mode, hex counter and units cleared,
//   result queue empty
// stall: when results.ready is low the queue holds its entries in order;
//   bytes keep coming in until the queue holds two results, then bytes.ready
//   drops until the receiver takes one
module json_string_unescape import jsu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  jsu_byte_if.sink     bytes,
  jsu_cp_if.source     results
);

  // parser state
  mode_t             mode, mode_next, mode_step;
  logic [1:0]        hex_cnt, hex_cnt_next;
  logic [UNIT_W-1:0] high_unit, high_next;
  logic [UNIT_W-1:0] low_unit, low_next;

  // result queue, entry 0 is the head
  result_t           q [QDEPTH];
  result_t           q_next [QDEPTH];
  logic [QCNT_W-1:0] q_cnt, q_cnt_next;

  logic              accept, pop;
  logic [7:0]        b;
  logic              last;
  logic [4:0]        hv;
  logic [8:0]        esc;
  logic              unit_done;
  logic [UNIT_W-1:0] new_unit;
  logic              fail;

  // results of the current byte
  logic [1:0]        n;
  result_t           r0, r1;

  assign accept = bytes.valid && bytes.ready;
  assign pop    = results.valid && results.ready;
  assign b      = bytes.byte_in;
  assign last   = bytes.last_byte;

  assign bytes.ready        = (q_cnt <= QCNT_W'(1));
  assign results.valid      = (q_cnt != '0);
  assign results.code_point = q[0].cp;
  assign results.status     = q[0].st;
  assign results.run_end    = q[0].fin;

  // shared decode of the byte
  assign hv        = hex_value(b);
  assign esc       = esc_map(b);
  assign unit_done = (hex_cnt == 2'd3);
  assign new_unit  = {((mode == M_HEX2) ? low_unit[11:0] : high_unit[11:0]), hv[3:0]};

  // next state
  always_comb begin
    mode_step    = mode;
    hex_cnt_next = hex_cnt;
    high_next    = high_unit;
    low_next     = low_unit;
    fail         = 1'b0;
    unique case (mode)
      M_NORMAL: begin
        if (b == CH_BSLASH && !last) mode_step = M_ESC;
      end
      M_ESC: begin
        mode_step = M_NORMAL;
        if (b == CH_U) begin
          mode_step    = M_HEX1;
          hex_cnt_next = '0;
          high_next    = '0;
        end else if (!esc[8]) begin
          fail = 1'b1;
        end
      end
      M_HEX1: begin
        if (!hv[4]) begin
          fail = 1'b1;
        end else begin
          high_next = new_unit;
          if (unit_done) begin
            hex_cnt_next = '0;
            if (new_unit < SURR_HI_MIN || new_unit > SURR_LO_MAX) mode_step = M_NORMAL;
            else if (new_unit <= SURR_HI_MAX) mode_step = M_BS2;
            else fail = 1'b1;
          end else begin
            hex_cnt_next = hex_cnt + 2'd1;
          end
        end
      end
      M_BS2: begin
        if (b == CH_BSLASH) mode_step = M_U2;
        else fail = 1'b1;
      end
      M_U2: begin
        if (b == CH_U) begin
          mode_step    = M_HEX2;
          hex_cnt_next = '0;
          low_next     = '0;
        end else begin
          fail = 1'b1;
        end
      end
      M_HEX2: begin
        if (!hv[4]) begin
          fail = 1'b1;
        end else begin
          low_next = new_unit;
          if (unit_done) begin
            hex_cnt_next = '0;
            if (new_unit >= SURR_LO_MIN && new_unit <= SURR_LO_MAX) mode_step = M_NORMAL;
            else fail = 1'b1;
          end else begin
            hex_cnt_next = hex_cnt + 2'd1;
          end
        end
      end
      default: ;
    endcase

    mode_next = mode_step;
    if (fail) begin
      hex_cnt_next = '0;
      mode_next    = last ? M_NORMAL : M_DROP;
    end else if (last) begin
      hex_cnt_next = '0;
      mode_next    = M_NORMAL;
    end
  end

  // results of this byte
  always_comb begin
    status_t err;
    logic    dropping;
    result_t tail;
    err      = ST_CODE;
    dropping = 1'b0;
    n        = '0;
    r0       = '0;
    r1       = '0;
    tail     = '0;
    unique case (mode)
      M_NORMAL: begin
        if (!(b == CH_BSLASH && !last)) begin
          n  = 2'd1;
          r0 = '{cp: CP_W'(b), st: ST_CODE, fin: 1'b0};
        end
      end
      M_ESC: begin
        if (esc[8]) begin
          n  = 2'd1;
          r0 = '{cp: CP_W'(esc[7:0]), st: ST_CODE, fin: 1'b0};
        end else if (b != CH_U) begin
          err = ST_BADESC;
        end
      end
      M_HEX1: begin
        if (!hv[4]) begin
          err = ST_BADUNI;
        end else if (unit_done) begin
          if (new_unit < SURR_HI_MIN || new_unit > SURR_LO_MAX) begin
            n  = 2'd1;
            r0 = '{cp: CP_W'(new_unit), st: ST_CODE, fin: 1'b0};
          end else if (new_unit > SURR_HI_MAX) begin
            err = ST_BADUNI;
          end
        end
      end
      M_BS2: begin
        if (b != CH_BSLASH) err = ST_BADUNI;
      end
      M_U2: begin
        if (b != CH_U) err = ST_BADUNI;
      end
      M_HEX2: begin
        if (!hv[4]) begin
          err = ST_BADUNI;
        end else if (unit_done) begin
          if (new_unit >= SURR_LO_MIN && new_unit <= SURR_LO_MAX) begin
            n  = 2'd1;
            r0 = '{cp: SUPP_BASE + CP_W'({high_unit[9:0], new_unit[9:0]}),
                   st: ST_CODE, fin: 1'b0};
          end else begin
            err = ST_BADUNI;
          end
        end
      end
      default: dropping = 1'b1;
    endcase

    // errors never follow a code point of the same byte
    if (err != ST_CODE) begin
      n  = 2'd1;
      r0 = '{cp: '0, st: err, fin: 1'b1};
    end else if (last && !dropping) begin
      // last byte inside an unfinished \u sequence is a truncation
      tail = '{cp: '0, st: (mode_step != M_NORMAL) ? ST_BADUNI : ST_END, fin: 1'b1};
      if (n == 2'd0) r0 = tail;
      else r1 = tail;
      n = n + 2'd1;
    end

    if (!accept) n = '0;
  end

  // queue: shift out on pop, append this byte's results behind what stays
  always_comb begin
    logic [QCNT_W-1:0] kept;
    kept = q_cnt - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
      if (pop) begin
        if (i < QDEPTH - 1) q_next[i] = q[i + 1];
      end
      if (n != 2'd0 && QCNT_W'(i) == kept) q_next[i] = r0;
      if (n == 2'd2 && QCNT_W'(i) == kept + QCNT_W'(1)) q_next[i] = r1;
    end
    q_cnt_next = kept + QCNT_W'(n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_NORMAL;
      hex_cnt   <= '0;
      high_unit <= '0;
      low_unit  <= '0;
      q_cnt     <= '0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        hex_cnt   <= hex_cnt_next;
        high_unit <= high_next;
        low_unit  <= low_next;
      end
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: hw/rtl/jsu_checker.sv
module jsu_checker import jsu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [1:0]  status,
  input logic        run_end
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a waiting result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(code_point) && $stable(status) && $stable(run_end))
    else $error("stalled result changed");

  // only closing statuses end a run, and every closing status does
  a_end_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_end == (status != ST_CODE)))
    else $error("run_end does not match status");

  // closing results carry no code point
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_CODE |-> code_point == '0)
    else $error("closing result carries a code point");

  // the queue comes out of reset empty and open for bytes
  a_no_ghost: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("queue not empty right after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (bytes.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .code_point (results.code_point),
  .status     (results.status),
  .run_end    (results.run_end)
);

FILE: tb/json_string_unescape_tb.sv
`timescale 1ns / 100ps

module json_string_unescape_tb;
  import jsu_pkg::*;

  // one request on the byte channel, plus the pacing hints that go with it
  typedef struct {
    logic [7:0] b;
    logic       last;
    int         phase;
    bit         hold;   // wait for every pending result before sending
  } byte_req_t;

  // idle percentages per phase: sender then receiver
  localparam int SRC_IDLE_PCT [3] = '{25, 50, 0};
  localparam int SNK_IDLE_PCT [3] = '{50, 25, 0};

  localparam int ITEM_TARGET = 1100;
  localparam int PHASE_LEN   = 370;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  // the eight single-letter escapes
  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                              CH_F, CH_N, CH_R, CH_T};

  logic clk;
  logic rst;

  jsu_byte_if bytes_if ();
  jsu_cp_if   results_if ();

  json_string_unescape i_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (results_if)
  );

  // stimulus store and expected code point / status store
  byte_req_t   raw_bytes_q [$];
  result_t     cp_expect_q [$];
  logic [7:0]  str_buf [$];

  // generator bookkeeping
  int          gen_phase = 0;
  int          gen_strings = 0;
  bit          hold_next = 0;

  // pacing and scoreboard counters
  int          cur_phase = 0;
  int unsigned results_pending = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_taken = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  // shadow copy of the unescaper's state
  mode_t       pmode = M_NORMAL;
  logic [1:0]  digits = '0;
  logic [15:0] hi_unit = '0;
  logic [15:0] lo_unit = '0;

  // clock: 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ------------------------------------------------------------------
  // helpers shared by prediction and generation
  // ------------------------------------------------------------------

  // {is hex digit, digit value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end
    // 'A'..'F' and 'a'..'f' share the low nibble 1..6
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'b0;
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  function automatic void push_result(input logic [20:0] cp, input status_t st, input logic fin);
    result_t r;
    r.cp  = cp;
    r.st  = st;
    r.fin = fin;
    cp_expect_q.push_back(r);
  endfunction

  // ------------------------------------------------------------------
  // predictor: one accepted byte in, zero to two expected results out
  // ------------------------------------------------------------------
  function automatic void unescape_byte(input logic [7:0] b, input logic last);
    status_t    err;
    logic       dropping;
    logic [4:0] nib;
    err      = ST_CODE;   // ST_CODE here means no error raised
    dropping = 1'b0;
    case (pmode)
      M_NORMAL: begin
        // a backslash on the final byte has nothing to escape, so it passes through
        if (b == CH_BSLASH && !last) begin
          pmode = M_ESC;
        end else begin
          push_result({13'b0, b}, ST_CODE, 1'b0);
        end
      end
      M_ESC: begin
        pmode = M_NORMAL;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: push_result({13'b0, b}, ST_CODE, 1'b0);
          CH_B: push_result({13'b0, CH_BS_CTL}, ST_CODE, 1'b0);
          CH_F: push_result({13'b0, CH_FF_CTL}, ST_CODE, 1'b0);
          CH_N: push_result({13'b0, CH_LF_CTL}, ST_CODE, 1'b0);
          CH_R: push_result({13'b0, CH_CR_CTL}, ST_CODE, 1'b0);
          CH_T: push_result({13'b0, CH_HT_CTL}, ST_CODE, 1'b0);
          CH_U: begin
            pmode   = M_HEX1;
            digits  = '0;
            hi_unit = '0;
          end
          default: err = ST_BADESC;
        endcase
      end
      M_HEX1: begin
        nib = nibble_of(b);
        if (!nib[4]) begin
          err = ST_BADUNI;
        end else begin
          hi_unit = {hi_unit[11:0], nib[3:0]};
          if (digits == 2'd3) begin
            digits = '0;
            if (hi_unit < SURR_HI_MIN || hi_unit > SURR_LO_MAX) begin
              // plain bmp unit, including the private use area at the top
              push_result({5'b0, hi_unit}, ST_CODE, 1'b0);
              pmode = M_NORMAL;
            end else if (hi_unit <= SURR_HI_MAX) begin
              pmode = M_BS2;
            end else begin
              // low surrogate with no high one before it
              err = ST_BADUNI;
            end
          end else begin
            digits = digits + 2'd1;
          end
        end
      end
      M_BS2: begin
        if (b == CH_BSLASH) pmode = M_U2;
        else err = ST_BADUNI;
      end
      M_U2: begin
        if (b == CH_U) begin
          pmode   = M_HEX2;
          digits  = '0;
          lo_unit = '0;
        end else begin
          err = ST_BADUNI;
        end
      end
      M_HEX2: begin
        nib = nibble_of(b);
        if (!nib[4]) begin
          err = ST_BADUNI;
        end else begin
          lo_unit = {lo_unit[11:0], nib[3:0]};
          if (digits == 2'd3) begin
            digits = '0;
            if (lo_unit >= SURR_LO_MIN && lo_unit <= SURR_LO_MAX) begin
              // both surrogate bases have zero low ten bits, so the offsets are slices
              push_result(SUPP_BASE + {1'b0, hi_unit[9:0], lo_unit[9:0]}, ST_CODE, 1'b0);
              pmode = M_NORMAL;
            end else begin
              err = ST_BADUNI;
            end
          end else begin
            digits = digits + 2'd1;
          end
        end
      end
      default: dropping = 1'b1;
    endcase

    if (err != ST_CODE) begin
      // error closes the run; rest of this string is swallowed
      push_result('0, err, 1'b1);
      digits = '0;
      pmode  = last ? M_NORMAL : M_DROP;
    end else if (last) begin
      // a dropped string ends without any result
      if (!dropping) begin
        push_result('0, (pmode != M_NORMAL) ? ST_BADUNI : ST_END, 1'b1);
      end
      pmode  = M_NORMAL;
      digits = '0;
    end
  endfunction

  // ------------------------------------------------------------------
  // string generation
  // ------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + n;
    end
    // mix upper and lower case letters
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [4:0] v;
    do begin
      c = 8'($urandom_range(255));
      v = nibble_of(c);
    end while (v[4]);
    return c;
  endfunction

  task automatic put_unit(input logic [15:0] u);
    str_buf.push_back(CH_BSLASH);
    str_buf.push_back(CH_U);
    for (int k = 3; k >= 0; k--) begin
      str_buf.push_back(hex_char(u[k*4 +: 4]));
    end
  endtask

  // a random surrogate pair, now and then at the corners of the ranges
  task automatic put_pair();
    logic [15:0] hi;
    logic [15:0] lo;
    case ($urandom_range(5))
      0: begin
        hi = SURR_HI_MIN;
        lo = SURR_LO_MIN;
      end
      1: begin
        hi = SURR_HI_MAX;
        lo = SURR_LO_MAX;
      end
      default: begin
        hi = 16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN));
        lo = 16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN));
      end
    endcase
    put_unit(hi);
    put_unit(lo);
  endtask

  // one well-formed piece of string body
  task automatic put_clean_token();
    logic [7:0]  c;
    logic [15:0] u;
    int          kind;
    kind = $urandom_range(9);
    if (kind <= 3) begin
      c = 8'($urandom_range(255));
      // a raw backslash must be doubled to stay well formed
      if (c == CH_BSLASH) str_buf.push_back(CH_BSLASH);
      str_buf.push_back(c);
    end else if (kind <= 5) begin
      str_buf.push_back(CH_BSLASH);
      str_buf.push_back(ESC_LETTERS[3'($urandom_range(7))]);
    end else if (kind <= 7) begin
      case ($urandom_range(5))
        0:       u = 16'h0000;
        1:       u = 16'hFFFF;
        2, 3:    u = 16'($urandom_range(16'hD7FF));
        default: u = 16'($urandom_range(16'hFFFF, 16'hE000));
      endcase
      put_unit(u);
    end else begin
      put_pair();
    end
  endtask

  task automatic put_noise_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30) str_buf.push_back(CH_BSLASH);
    else if (r < 45) str_buf.push_back(CH_U);
    else if (r < 65) str_buf.push_back(hex_char(4'($urandom_range(15))));
    else str_buf.push_back(8'($urandom_range(255)));
  endtask

  // move the string buffer into the request queue, last flag on its final byte
  task automatic commit_string();
    byte_req_t r;
    foreach (str_buf[i]) begin
      r.b     = str_buf[i];
      r.last  = (i == str_buf.size() - 1);
      r.phase = gen_phase;
      r.hold  = hold_next && (i == 0);
      raw_bytes_q.push_back(r);
    end
    str_buf.delete();
    hold_next = 0;
    gen_strings++;
  endtask

  task automatic add_random_string();
    int          r;
    int          n;
    int          base;
    logic [7:0]  c;
    logic [15:0] u;
    bit          known;
    bit          truncated;
    r = $urandom_range(99);
    truncated = 0;
    if (r < 70) begin
      // mostly well formed so the deep states get exercised
      n = $urandom_range(8, 1);
      repeat (n) put_clean_token();
      if ($urandom_range(19) == 0) str_buf.push_back(CH_BSLASH);
    end else if (r < 90) begin
      // clean prefix, one defect, then bytes that should be swallowed
      n = $urandom_range(3);
      repeat (n) put_clean_token();
      case ($urandom_range(7))
        0: begin
          // unknown escape letter
          do begin
            c = 8'($urandom_range(255));
            known = (c == CH_U);
            foreach (ESC_LETTERS[k]) if (c == ESC_LETTERS[k]) known = 1;
          end while (known);
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(c);
        end
        1: begin
          // non-hex digit inside the first unit
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(CH_U);
          repeat ($urandom_range(3)) str_buf.push_back(hex_char(4'($urandom_range(15))));
          str_buf.push_back(non_hex_byte());
        end
        2: put_unit(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));   // lone low surrogate
        3: begin
          // high surrogate not followed by a backslash
          put_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
          do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
          str_buf.push_back(c);
        end
        4: begin
          // high surrogate, backslash, then something other than u
          put_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
          str_buf.push_back(CH_BSLASH);
          do c = 8'($urandom_range(255)); while (c == CH_U);
          str_buf.push_back(c);
        end
        5: begin
          // non-hex digit inside the second unit
          put_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(CH_U);
          repeat ($urandom_range(3)) str_buf.push_back(hex_char(4'($urandom_range(15))));
          str_buf.push_back(non_hex_byte());
        end
        6: begin
          // high surrogate followed by a unit that is not a low surrogate
          put_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
          u = 16'($urandom_range(16'hFFFF));
          if (u >= SURR_LO_MIN && u <= SURR_LO_MAX) u = u - 16'h0400;
          put_unit(u);
        end
        default: begin
          // string ends partway through a unit or a pair
          base = str_buf.size();
          put_pair();
          n = $urandom_range(11, 1);
          while (str_buf.size() > base + n) void'(str_buf.pop_back());
          truncated = 1;
        end
      endcase
      if (!truncated) repeat ($urandom_range(4)) put_noise_byte();
    end else begin
      // pure noise
      n = $urandom_range(6, 1);
      repeat (n) put_noise_byte();
    end
    commit_string();
  endtask

  // ------------------------------------------------------------------
  // driver: byte requests from the pending queue
  // ------------------------------------------------------------------
  always @(posedge clk) begin : drive
    byte_req_t nxt;
    if (rst) begin
      bytes_if.valid     <= 1'b0;
      bytes_if.byte_in   <= '0;
      bytes_if.last_byte <= 1'b0;
    end else if (!bytes_if.valid || bytes_if.ready) begin
      // a held request waits until no byte is in flight and nothing is pending
      if (raw_bytes_q.size() != 0 &&
          !(raw_bytes_q[0].hold && (bytes_if.valid || results_pending != 0)) &&
          $urandom_range(99) >= SRC_IDLE_PCT[raw_bytes_q[0].phase]) begin
        nxt = raw_bytes_q.pop_front();
        bytes_if.valid     <= 1'b1;
        bytes_if.byte_in   <= nxt.b;
        bytes_if.last_byte <= nxt.last;
        cur_phase          <= nxt.phase;
      end else begin
        bytes_if.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= SNK_IDLE_PCT[cur_phase]);
    end
  end

  // ------------------------------------------------------------------
  // monitor: check results first, then predict from the byte taken this edge
  // ------------------------------------------------------------------
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        results_taken++;
        status_seen[results_if.status]++;
        if (cp_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected result cp=%h status=%0d run_end=%b",
                               results_if.code_point, results_if.status, results_if.run_end));
        end else begin
          want = cp_expect_q.pop_front();
          if (results_if.code_point !== want.cp || results_if.status !== want.st ||
              results_if.run_end !== want.fin) begin
            flag_error($sformatf(
              "result %0d: expected cp=%h status=%0d run_end=%b, got cp=%h status=%0d run_end=%b",
              results_taken, want.cp, want.st, want.fin,
              results_if.code_point, results_if.status, results_if.run_end));
          end
        end
      end
      if (bytes_if.valid && bytes_if.ready) begin
        bytes_taken++;
        unescape_byte(bytes_if.byte_in, bytes_if.last_byte);
      end
      results_pending <= cp_expect_q.size();
    end
  end

  // watchdog: too long without any request on either side
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] ERROR: no progress for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // stimulus, reset and end of run
  // ------------------------------------------------------------------
  initial begin : stimulus
    rst = 1'b1;

    // byte extremes as plain text, then every single-letter escape
    str_buf = '{8'h00, 8'hFF, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SLASH,
                CH_BSLASH, CH_B, CH_BSLASH, CH_F, CH_BSLASH, CH_N, CH_BSLASH, CH_R,
                CH_BSLASH, CH_T};
    commit_string();
    // lone backslash as the final byte goes through literally
    str_buf = '{CH_BSLASH};
    commit_string();
    // unknown escape, then a swallowed final byte
    str_buf = '{CH_BSLASH, 8'hFF, 8'h7F};
    commit_string();

    // random strings in three pacing phases, draining at each phase change
    while (raw_bytes_q.size() < ITEM_TARGET) begin
      if (gen_phase < 2 && raw_bytes_q.size() >= PHASE_LEN * (gen_phase + 1)) begin
        gen_phase++;
        hold_next = 1;
      end
      add_random_string();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so driver updates have settled
    do @(negedge clk);
    while (raw_bytes_q.size() != 0 || bytes_if.valid || results_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (cp_expect_q.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", cp_expect_q.size()));
    end

    $display("sent %0d bytes in %0d strings, checked %0d results, %0d mismatches",
             bytes_taken, gen_strings, results_taken, mismatch_cnt);
    $display("code points %0d, clean ends %0d, bad escapes %0d, bad unicode %0d",
             status_seen[ST_CODE], status_seen[ST_END], status_seen[ST_BADESC],
             status_seen[ST_BADUNI]);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
